>>> hdl/joystick_sector_relay_mapper_macros.svh
// Assertion macros shared by the joystick sector relay mapper.
// Each check is sampled on aclk and switched off while aresetn is low.
`ifndef JOYSTICK_SECTOR_RELAY_MAPPER_MACROS_SVH
`define JOYSTICK_SECTOR_RELAY_MAPPER_MACROS_SVH

`ifndef SYNTH

`define JSRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define JSRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define JSRM_ASSERT_NOW(label, ante, cons, msg)

`define JSRM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> hdl/jsrm_pkg.sv
package jsrm_pkg;

    localparam int SECTOR_COUNT = 12;

    localparam int SAMPLE_W = 8;
    localparam int LEVEL_W  = 9;
    localparam int DELTA_W  = SAMPLE_W + 1;
    localparam int SQUARE_W = 2 * SAMPLE_W;
    localparam int DIST_W   = SQUARE_W + 1;
    localparam int ENTER_W  = 19;
    localparam int EXIT_W   = 2 * LEVEL_W;
    localparam int MASK_W   = 6;
    localparam int SECTOR_W = 4;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_VALUE = 2'd0,
        REG_ENTER_LEVEL  = 2'd1,
        REG_EXIT_LEVEL   = 2'd2
    } cfg_reg_t;

    // Reset values: centre 127, enter squared (60 + 1)^2, exit squared 40^2.
    localparam logic [SAMPLE_W-1:0] CENTER_RESET   = 8'd127;
    localparam logic [ENTER_W-1:0]  ENTER_SQ_RESET = 19'd3721;
    localparam logic [EXIT_W-1:0]   EXIT_SQ_RESET  = 18'd1600;

    localparam logic [SECTOR_W-1:0] SECTOR_LAST = SECTOR_W'(SECTOR_COUNT - 1);
    localparam logic [SECTOR_W-1:0] SECTOR_UP   = 4'd6;

    // Offsets and their squares handed to the direction classifier.
    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic [SQUARE_W-1:0]       x2;
        logic [SQUARE_W-1:0]       y2;
    } offset_t;

    function automatic logic [MASK_W-1:0] sector_mask(input logic [SECTOR_W-1:0] sector);
        logic [MASK_W-1:0] mask;
        case (sector)
            4'd0:    mask = 6'h08;
            4'd1:    mask = 6'h18;
            4'd2:    mask = 6'h10;
            4'd3:    mask = 6'h30;
            4'd4:    mask = 6'h20;
            4'd5:    mask = 6'h21;
            4'd6:    mask = 6'h01;
            4'd7:    mask = 6'h03;
            4'd8:    mask = 6'h02;
            4'd9:    mask = 6'h06;
            4'd10:   mask = 6'h04;
            4'd11:   mask = 6'h0C;
            default: mask = '0;
        endcase
        return mask;
    endfunction

endpackage

>>> hdl/jsrm_sector.sv
module jsrm_sector (
    input  jsrm_pkg::offset_t             offset,
    output logic [jsrm_pkg::SECTOR_W-1:0] sector
);
    import jsrm_pkg::*;

    logic [SQUARE_W+1:0] x2_w;
    logic [SQUARE_W+1:0] y2_w;
    logic [SQUARE_W+1:0] x2_3;
    logic [SQUARE_W+1:0] y2_3;
    logic [1:0]          third_y;
    logic [1:0]          third_x;
    logic                dx_zero;
    logic                dy_zero;

    assign x2_w = {2'b00, offset.x2};
    assign y2_w = {2'b00, offset.y2};
    assign x2_3 = x2_w + {1'b0, offset.x2, 1'b0};
    assign y2_3 = y2_w + {1'b0, offset.y2, 1'b0};

    // Third of a quadrant whose start axis is y (p = |dy|, q = |dx|).
    assign third_y = (x2_w >= y2_3) ? 2'd2 : ((x2_3 >= y2_w) ? 2'd1 : 2'd0);
    // Third of a quadrant whose start axis is x (p = |dx|, q = |dy|).
    assign third_x = (y2_w >= x2_3) ? 2'd2 : ((y2_3 >= x2_w) ? 2'd1 : 2'd0);

    assign dx_zero = (offset.dx == '0);
    assign dy_zero = (offset.dy == '0);

    always_comb begin
        if (dx_zero && dy_zero) begin
            sector = SECTOR_UP;
        end else if (dx_zero && offset.dy < 0) begin
            // Straight down sits on the +180 degree edge and folds into the last sector.
            sector = SECTOR_LAST;
        end else if (offset.dx >= 0 && offset.dy > 0) begin
            sector = 4'd6 + {2'b00, third_y};
        end else if (offset.dx > 0) begin
            sector = 4'd9 + {2'b00, third_x};
        end else if (offset.dy >= 0) begin
            sector = 4'd3 + {2'b00, third_x};
        end else begin
            sector = {2'b00, third_y};
        end
    end

endmodule

>>> hdl/joystick_sector_relay_mapper.sv
// Joystick sector relay mapper.
// A request on the s_ channel carries one raw joystick sample (x, y). Each
// request yields exactly one result on the m_ channel: the relay drive mask,
// the engaged flag after that sample and the 30 degree direction sector.
// Both channels use valid/ready. The block is a two-register pipeline: the
// sample is offset from the centre value as it is captured, and the squares,
// hysteresis compare and sector lookup are resolved on the way into the
// result register. A request moves from the capture register into the
// result register once that is free, which raises m_valid, and one
// request is taken every cycle while the receiver keeps up.
// When m_ready is low the result register holds and the capture register
// fills; s_ready then drops until the result is taken.
// The configuration port writes the centre value or the enter or exit level,
// one per write as cfg_index selects; the levels are stored as squares, squared on the write.
// Writes belong to idle periods. aresetn (synchronous, active low) empties
// the pipeline, clears the engaged flag and restores the register defaults.
module joystick_sector_relay_mapper (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [jsrm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jsrm_pkg::LEVEL_W-1:0]     cfg_wdata,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [jsrm_pkg::SAMPLE_W-1:0]    s_joystick_x,
    input  logic [jsrm_pkg::SAMPLE_W-1:0]    s_joystick_y,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [jsrm_pkg::MASK_W-1:0]      m_relay_mask,
    output logic                             m_engaged,
    output logic [jsrm_pkg::SECTOR_W-1:0]    m_sector
);
    import jsrm_pkg::*;

    `include "joystick_sector_relay_mapper_macros.svh"

    logic [SAMPLE_W-1:0]      center_reg;
    logic [ENTER_W-1:0]       enter_sq_reg;
    logic [EXIT_W-1:0]        exit_sq_reg;
    logic [LEVEL_W:0]         enter_p1;
    logic [2*LEVEL_W+1:0]     enter_sq_full;
    logic [2*LEVEL_W-1:0]     exit_sq_full;

    logic                     in_valid_reg;
    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [DELTA_W-1:0] dy_reg;
    logic signed [DELTA_W-1:0] dx_next;
    logic signed [DELTA_W-1:0] dy_next;

    logic                     out_valid_reg;
    logic [MASK_W-1:0]        mask_reg;
    logic [SECTOR_W-1:0]      sector_reg;
    logic                     engaged_flag_reg;
    logic                     engaged_next;

    logic                     advance;
    logic                     take;
    logic [SAMPLE_W-1:0]      ax;
    logic [SAMPLE_W-1:0]      ay;
    logic [DIST_W-1:0]        dist_sq;
    offset_t                  offset;
    logic [SECTOR_W-1:0]      sector_raw;

    // Configuration: levels kept as squares so the data path only compares.
    assign enter_p1      = {1'b0, cfg_wdata} + 10'd1;
    assign enter_sq_full = enter_p1 * enter_p1;
    assign exit_sq_full  = cfg_wdata * cfg_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg   <= CENTER_RESET;
            enter_sq_reg <= ENTER_SQ_RESET;
            exit_sq_reg  <= EXIT_SQ_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CENTER_VALUE: center_reg   <= cfg_wdata[SAMPLE_W-1:0];
                REG_ENTER_LEVEL:  enter_sq_reg <= enter_sq_full[ENTER_W-1:0];
                REG_EXIT_LEVEL:   exit_sq_reg  <= exit_sq_full;
                default: ;
            endcase
        end
    end

    // Handshake: the capture stage moves on when the result register is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take    = s_valid && s_ready;

    assign dx_next = $signed({1'b0, s_joystick_x}) - $signed({1'b0, center_reg});
    assign dy_next = $signed({1'b0, s_joystick_y}) - $signed({1'b0, center_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // Second half: squares, hysteresis and direction.
    assign ax = dx_reg[DELTA_W-1] ? SAMPLE_W'(-dx_reg) : dx_reg[SAMPLE_W-1:0];
    assign ay = dy_reg[DELTA_W-1] ? SAMPLE_W'(-dy_reg) : dy_reg[SAMPLE_W-1:0];

    assign offset.dx = dx_reg;
    assign offset.dy = dy_reg;
    assign offset.x2 = ax * ax;
    assign offset.y2 = ay * ay;
    assign dist_sq   = {1'b0, offset.x2} + {1'b0, offset.y2};

    always_comb begin
        engaged_next = engaged_flag_reg;
        if (!engaged_flag_reg && ({2'b00, dist_sq} >= enter_sq_reg)) begin
            engaged_next = 1'b1;
        end else if (engaged_flag_reg && ({1'b0, dist_sq} < exit_sq_reg)) begin
            engaged_next = 1'b0;
        end
    end

    jsrm_sector u_sector (
        .offset (offset),
        .sector (sector_raw)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg    <= 1'b0;
            engaged_flag_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg    <= 1'b1;
            engaged_flag_reg <= engaged_next;
        end else if (m_ready) begin
            out_valid_reg    <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sector_reg <= engaged_next ? sector_raw : '0;
            mask_reg   <= engaged_next ? sector_mask(sector_raw) : '0;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_relay_mask = mask_reg;
    assign m_engaged    = engaged_flag_reg;
    assign m_sector     = sector_reg;

    `JSRM_ASSERT_NOW(a_idle_outputs_zero, m_valid && !m_engaged, m_relay_mask == '0 && m_sector == '0, "released result carries a mask or sector")
    `JSRM_ASSERT_NOW(a_sector_in_range, m_valid && m_engaged, m_sector <= SECTOR_LAST && m_relay_mask != '0, "engaged result has a bad sector or an empty mask")
    `JSRM_ASSERT_NEXT(a_flag_moves_with_item, !advance, $stable(engaged_flag_reg), "engaged flag changed without a request passing")
    `JSRM_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_sector) && $stable(m_relay_mask), "stalled result was not held")

endmodule

>>> tb/sv/tb_joystick_sector_relay_mapper.sv
`timescale 1ns / 100ps

module tb_joystick_sector_relay_mapper;
    import jsrm_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 131;
    localparam int PHASE_COUNT = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Relay drive pattern for each 30 degree sector, sector 0 pointing straight down.
    localparam logic [MASK_W-1:0] RELAY_PATTERN [SECTOR_COUNT] = '{
        6'h08, 6'h18, 6'h10, 6'h30, 6'h20, 6'h21,
        6'h01, 6'h03, 6'h02, 6'h06, 6'h04, 6'h0C
    };

    typedef struct packed {
        logic [MASK_W-1:0]   mask;
        logic                engaged;
        logic [SECTOR_W-1:0] sector;
    } relay_result_t;

    class relay_scoreboard;
        relay_result_t       relay_expected[$];
        logic [SAMPLE_W-1:0] centre;
        logic [LEVEL_W-1:0]  enter_lvl;
        logic [LEVEL_W-1:0]  exit_lvl;
        bit                  engaged_now;
        int                  errors;
        int                  samples_seen;
        int                  results_checked;
        int                  settings_used;

        function new();
            centre          = 8'd127;
            enter_lvl       = 9'd60;
            exit_lvl        = 9'd40;
            engaged_now     = 1'b0;
            errors          = 0;
            samples_seen    = 0;
            results_checked = 0;
            settings_used   = 1;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] data);
            case (idx)
                REG_CENTER_VALUE: centre    = data[SAMPLE_W-1:0];
                REG_ENTER_LEVEL:  enter_lvl = data;
                REG_EXIT_LEVEL:   exit_lvl  = data;
                default: ;
            endcase
            settings_used++;
        endfunction

        // Which third of a quadrant the vector lies in; p runs along the start axis.
        static function int span_third(input int p, input int q);
            if (q * q >= 3 * p * p) return 2;
            if (3 * q * q >= p * p) return 1;
            return 0;
        endfunction

        static function logic [SECTOR_W-1:0] heading_sector(input int dx, input int dy);
            int s;
            if (dx == 0 && dy == 0) s = 6;
            else if (dx == 0 && dy < 0) s = 11;
            else if (dx >= 0 && dy > 0) s = 6 + span_third(dy, dx);
            else if (dx > 0) s = 9 + span_third(dx, -dy);
            else if (dy >= 0) s = 3 + span_third(-dx, dy);
            else s = span_third(-dy, -dx);
            if (s > SECTOR_COUNT - 1) s = SECTOR_COUNT - 1;
            return s[SECTOR_W-1:0];
        endfunction

        function void note_sample(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y);
            int            dx;
            int            dy;
            int            dist_sq;
            int            enter_sq;
            int            exit_sq;
            relay_result_t res;
            dx       = int'(x) - int'(centre);
            dy       = int'(y) - int'(centre);
            dist_sq  = dx * dx + dy * dy;
            enter_sq = (int'(enter_lvl) + 1) * (int'(enter_lvl) + 1);
            exit_sq  = int'(exit_lvl) * int'(exit_lvl);
            // Engage is tried first; release only applies when already engaged.
            if (!engaged_now && dist_sq >= enter_sq) engaged_now = 1'b1;
            else if (engaged_now && dist_sq < exit_sq) engaged_now = 1'b0;
            res = '0;
            res.engaged = engaged_now;
            if (engaged_now) begin
                res.sector = heading_sector(dx, dy);
                res.mask   = RELAY_PATTERN[res.sector];
            end
            relay_expected.push_back(res);
            samples_seen++;
        endfunction

        function void check_result(input logic [MASK_W-1:0] mask, input logic engaged,
                                   input logic [SECTOR_W-1:0] sector);
            relay_result_t exp_res;
            if (relay_expected.size() == 0) begin
                $display("%0t: result with no request outstanding: mask %0h engaged %0b sector %0d",
                         $time, mask, engaged, sector);
                errors++;
                return;
            end
            exp_res = relay_expected.pop_front();
            results_checked++;
            if (mask !== exp_res.mask) begin
                $display("%0t: relay_mask mismatch, expected %0h, actual %0h",
                         $time, exp_res.mask, mask);
                errors++;
            end
            if (engaged !== exp_res.engaged) begin
                $display("%0t: engaged mismatch, expected %0b, actual %0b",
                         $time, exp_res.engaged, engaged);
                errors++;
            end
            if (sector !== exp_res.sector) begin
                $display("%0t: sector mismatch, expected %0d, actual %0d",
                         $time, exp_res.sector, sector);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEVEL_W-1:0]   cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [SAMPLE_W-1:0]  s_joystick_x;
    logic [SAMPLE_W-1:0]  s_joystick_y;
    logic                 m_valid;
    logic                 m_ready;
    logic [MASK_W-1:0]    m_relay_mask;
    logic                 m_engaged;
    logic [SECTOR_W-1:0]  m_sector;

    relay_scoreboard sb;
    int              idle_pct;
    int              stall_pct;
    int              quiet_cycles;

    joystick_sector_relay_mapper i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_joystick_x (s_joystick_x),
        .s_joystick_y (s_joystick_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_relay_mask (m_relay_mask),
        .m_engaged    (m_engaged),
        .m_sector     (m_sector)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= (int'($urandom_range(99)) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_sample(s_joystick_x, s_joystick_y);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_relay_mask, m_engaged, m_sector);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("tb_joystick_sector_relay_mapper: FAIL");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] to_byte(input int v);
        if (v < 0) return '0;
        if (v > 255) return 8'hFF;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic int root_floor(input int v);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    // Entered and left at a falling edge.
    task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y);
        while (int'($urandom_range(99)) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_joystick_x <= x;
        s_joystick_y <= y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.relay_expected.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] data);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_levels(input logic [LEVEL_W-1:0] centre_w, input logic [LEVEL_W-1:0] enter_w,
                              input logic [LEVEL_W-1:0] exit_w);
        program_reg(REG_CENTER_VALUE, centre_w);
        program_reg(REG_ENTER_LEVEL, enter_w);
        program_reg(REG_EXIT_LEVEL, exit_w);
    endtask

    // Mostly points on or near the hysteresis circles, plus axis and diagonal
    // directions, small wobbles around the centre and raw noise.
    task automatic random_sample(output logic [SAMPLE_W-1:0] x, output logic [SAMPLE_W-1:0] y);
        int kind;
        int lvl;
        int dx;
        int dy;
        int m;
        kind = $urandom_range(99);
        dx = 0;
        dy = 0;
        if (kind < 25) begin
            x = SAMPLE_W'($urandom);
            y = SAMPLE_W'($urandom);
            return;
        end else if (kind < 80) begin
            lvl = ($urandom_range(1) != 0) ? int'(sb.enter_lvl) + 1 : int'(sb.exit_lvl);
            lvl = lvl + int'($urandom_range(4)) - 2;
            if (lvl < 0) lvl = 0;
            dx = int'($urandom_range(2 * lvl)) - lvl;
            dy = root_floor(lvl * lvl - dx * dx);
            if ($urandom_range(1) != 0) dy = -dy;
        end else if (kind < 92) begin
            m = $urandom_range(130, 1);
            case ($urandom_range(7))
                0: begin dx = m;  dy = 0;  end
                1: begin dx = -m; dy = 0;  end
                2: begin dx = 0;  dy = m;  end
                3: begin dx = 0;  dy = -m; end
                4: begin dx = m;  dy = m;  end
                5: begin dx = m;  dy = -m; end
                6: begin dx = -m; dy = m;  end
                default: begin dx = -m; dy = -m; end
            endcase
        end else begin
            dx = int'($urandom_range(6)) - 3;
            dy = int'($urandom_range(6)) - 3;
        end
        x = to_byte(int'(sb.centre) + dx);
        y = to_byte(int'(sb.centre) + dy);
    endtask

    task automatic set_idling(input int profile);
        case (profile)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 54; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 54; end
            default: begin idle_pct = 31; stall_pct = 31; end
        endcase
    endtask

    task automatic run_directed();
        // Default levels, with bit 8 of the centre write to be masked off.
        set_levels(9'h17F, 9'd60, 9'd40);
        send_sample(8'd127, 8'd127);
        send_sample(8'd187, 8'd127);   // exactly the enter level, not past it
        send_sample(8'd188, 8'd127);
        send_sample(8'd127, 8'd255);
        send_sample(8'd255, 8'd255);
        send_sample(8'd0,   8'd255);
        send_sample(8'd0,   8'd127);
        send_sample(8'd0,   8'd0);
        send_sample(8'd127, 8'd0);     // straight down clamps into the last sector
        send_sample(8'd255, 8'd0);
        send_sample(8'd167, 8'd127);   // exactly the exit level holds engagement
        send_sample(8'd166, 8'd127);
        // With a zero exit level the centre itself stays engaged.
        set_levels(9'd127, 9'd0, 9'd0);
        send_sample(8'd128, 8'd127);
        send_sample(8'd127, 8'd127);
        // Enter below exit: the flag toggles on every sample.
        set_levels(9'd0, 9'd10, 9'd100);
        send_sample(8'd30, 8'd40);
        send_sample(8'd30, 8'd40);
        send_sample(8'd30, 8'd40);
        set_levels(9'h0FF, 9'd511, 9'd511);
        send_sample(8'd0,   8'd0);
        send_sample(8'd255, 8'd255);
        program_reg(REG_SPARE, 9'h1FF);
        program_reg(REG_ENTER_LEVEL, 9'd0);
        send_sample(8'd254, 8'd255);
        send_sample(8'd0,   8'd0);
    endtask

    initial begin
        logic [SAMPLE_W-1:0] x;
        logic [SAMPLE_W-1:0] y;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_joystick_x = '0;
        s_joystick_y = '0;
        m_ready      = 1'b0;
        quiet_cycles = 0;
        sb           = new();
        set_idling(0);
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: set_levels(9'd127, 9'd60, 9'd40);
                1: set_levels(9'd255, 9'd0, 9'd0);
                2: set_levels(9'd0, 9'd30, 9'd90);
                3: set_levels(9'd127, 9'd200, 9'd180);
                default: set_levels(LEVEL_W'($urandom_range(511)),
                                    LEVEL_W'($urandom_range(140)),
                                    LEVEL_W'($urandom_range(140)));
            endcase
            set_idling(phase % 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_sample(x, y);
                send_sample(x, y);
            end
        end

        wait_idle();
        set_idling(0);
        repeat (8) @(negedge aclk);
        sb.errors += sb.relay_expected.size();
        $display("Checked %0d results from %0d joystick samples over %0d register writes,",
                 sb.results_checked, sb.samples_seen, sb.settings_used - 1);
        $display("with hysteresis edges, all sectors and sender/receiver idling phases.");
        if (sb.errors == 0) begin
            $display("tb_joystick_sector_relay_mapper: PASS");
        end else begin
            $display("tb_joystick_sector_relay_mapper: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/jsrm_pkg.sv
hdl/jsrm_sector.sv
hdl/joystick_sector_relay_mapper.sv
tb/sv/tb_joystick_sector_relay_mapper.sv
